// ===== hdl/wsts_pkg.sv =====
// ---------------------------------------------------------------------------
// wsts_pkg
// types and constants of the withstand test stage sequencer
// ---------------------------------------------------------------------------
package wsts_pkg;

    localparam int TIME_W  = 14;
    localparam int COUNT_W = 16;
    localparam int BOUND_W = 17;
    localparam int STAGE_W = 3;
    localparam int INDEX_W = 3;

    // stage codes
    localparam logic [STAGE_W-1:0] ST_READY    = 3'd0;
    localparam logic [STAGE_W-1:0] ST_RISE     = 3'd1;
    localparam logic [STAGE_W-1:0] ST_CHANGE   = 3'd2;
    localparam logic [STAGE_W-1:0] ST_TEST     = 3'd3;
    localparam logic [STAGE_W-1:0] ST_FALL     = 3'd4;
    localparam logic [STAGE_W-1:0] ST_CONTINUE = 3'd5;
    localparam logic [STAGE_W-1:0] ST_OVER     = 3'd6;

    // item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // register indexes
    localparam logic [INDEX_W-1:0] REG_RISE  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_GAP   = 3'd1;
    localparam logic [INDEX_W-1:0] REG_HOLD  = 3'd2;
    localparam logic [INDEX_W-1:0] REG_FALL  = 3'd3;
    localparam logic [INDEX_W-1:0] REG_FIRST = 3'd4;
    localparam logic [INDEX_W-1:0] REG_LAST  = 3'd5;

    localparam logic [BOUND_W-1:0] ENDLESS_LIMIT = 17'd9999;

    // endless display wrap period
    localparam int WRAP_STEP = 10000;

    typedef struct packed {
        logic               endless;
        logic               set_level;
        logic               ramp_start;
        logic               ramping;
        logic [TIME_W-1:0]  stage_time;
        logic [STAGE_W-1:0] stage;
    } result_t;

endpackage

// ===== hdl/withstand_test_stage_sequencer.sv =====
// ---------------------------------------------------------------------------
// withstand_test_stage_sequencer
// stage sequencing of one high-voltage test step from timer ticks
// ---------------------------------------------------------------------------
// One input transfer (a timer tick or a step start) gives one result transfer.
// A transfer can be taken every cycle while the output is not stalled by m_tready; the result
// passes through the input register, the combinational stage classification and the result
// register. The elapsed count, endless flag and finished flag are updated as each item
// passes the classification stage.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data.
module withstand_test_stage_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [wsts_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [wsts_pkg::TIME_W-1:0]   cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // fail_seen
    input  logic [0:0]                    s_tuser,   // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // stage, stage_time, ramping, ramp_start, set_level, endless, zero fill
    output logic [23:0]                   m_tdata
);
    import wsts_pkg::*;

    logic [TIME_W-1:0]  rise_reg, gap_reg, hold_reg, fall_reg;
    logic               first_reg, last_reg;

    logic               in_valid_reg, in_kind_reg, in_fail_reg;
    logic               out_valid_reg;
    result_t            res_reg, res_next;

    logic [COUNT_W-1:0] elapsed_reg, elapsed_next;
    logic               endless_reg, endless_next;
    logic               finished_reg, finished_next;

    logic               advance;
    logic [BOUND_W-1:0] b1, b2, b3, b4, ev, t17;
    logic [COUNT_W-1:0] e_inc, wrap_rem;
    logic [STAGE_W-1:0] end_stage;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, res_reg};

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_reg  <= '0;
            gap_reg   <= '0;
            hold_reg  <= '0;
            fall_reg  <= '0;
            first_reg <= 1'b1;
            last_reg  <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_RISE:  rise_reg  <= cfg_data;
                REG_GAP:   gap_reg   <= cfg_data;
                REG_HOLD:  hold_reg  <= cfg_data;
                REG_FALL:  fall_reg  <= cfg_data;
                REG_FIRST: first_reg <= cfg_data[0];
                REG_LAST:  last_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage boundaries and endless wrap remainder
    always_comb begin
        b1 = first_reg ? {3'b000, rise_reg} : '0;
        b2 = b1 + {3'b000, gap_reg};
        b3 = b2 + {3'b000, hold_reg};
        b4 = last_reg ? b3 + {3'b000, fall_reg} : b3;
        e_inc = elapsed_reg + 16'd1;
        ev = {1'b0, e_inc};
        end_stage = (hold_reg != '0 && !last_reg) ? ST_CONTINUE : ST_OVER;
        wrap_rem = e_inc;
        for (int k = 1; k < 7; k++) begin
            if (e_inc >= COUNT_W'(k * WRAP_STEP)) begin
                wrap_rem = e_inc - COUNT_W'(k * WRAP_STEP);
            end
        end
    end

    // classification
    always_comb begin
        elapsed_next  = elapsed_reg;
        endless_next  = endless_reg;
        finished_next = finished_reg;
        res_next      = '0;
        t17           = ev - b1;
        if (in_kind_reg == KIND_START) begin
            elapsed_next     = '0;
            endless_next     = 1'b0;
            finished_next    = 1'b0;
            res_next.stage   = ST_READY;
            res_next.ramping = 1'b1;
        end else if (finished_reg) begin
            res_next.stage = end_stage;
        end else begin
            elapsed_next = e_inc;
            if (hold_reg == '0) begin
                if (endless_reg) begin
                    if (wrap_rem == '0) begin
                        elapsed_next = '0;
                    end
                    res_next.stage      = ST_TEST;
                    res_next.stage_time = wrap_rem[TIME_W-1:0];
                end else if (e_inc == '0) begin
                    res_next.stage   = ST_READY;
                    res_next.ramping = 1'b1;
                end else if (ev <= b1) begin
                    res_next.stage      = ST_RISE;
                    res_next.stage_time = e_inc[TIME_W-1:0];
                    res_next.ramping    = 1'b1;
                    res_next.ramp_start = (e_inc == 16'd1);
                end else begin
                    res_next.set_level = (ev == b1 + 17'd1);
                    if (in_fail_reg) begin
                        finished_next  = 1'b1;
                        res_next.stage = ST_OVER;
                    end else begin
                        if (t17 >= ENDLESS_LIMIT) begin
                            elapsed_next = '0;
                            endless_next = 1'b1;
                        end
                        res_next.stage      = ST_TEST;
                        res_next.stage_time = t17[TIME_W-1:0];
                    end
                end
            end else if (e_inc == '0) begin
                res_next.stage   = ST_READY;
                res_next.ramping = 1'b1;
            end else if (ev <= b1) begin
                res_next.stage      = ST_RISE;
                res_next.stage_time = e_inc[TIME_W-1:0];
                res_next.ramping    = 1'b1;
                res_next.ramp_start = (e_inc == 16'd1);
            end else if (ev <= b2) begin
                res_next.stage      = ST_CHANGE;
                res_next.stage_time = t17[TIME_W-1:0];
                res_next.ramping    = 1'b1;
            end else if (ev <= b3) begin
                res_next.stage      = ST_TEST;
                res_next.stage_time = TIME_W'(ev - b2);
                res_next.set_level  = (ev == b1 + 17'd1);
            end else if (ev <= b4) begin
                res_next.stage      = ST_FALL;
                res_next.stage_time = TIME_W'(ev - b3);
                res_next.ramping    = 1'b1;
                res_next.ramp_start = (ev - b3 == 17'd1);
            end else begin
                finished_next  = 1'b1;
                res_next.stage = end_stage;
            end
        end
        res_next.endless = endless_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            elapsed_reg   <= '0;
            endless_reg   <= 1'b0;
            finished_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                elapsed_reg   <= elapsed_next;
                endless_reg   <= endless_next;
                finished_reg  <= finished_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_kind_reg <= s_tuser[0];
            in_fail_reg <= s_tdata[0];
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_kind_reg == KIND_START)
        |=> (elapsed_reg == '0 && !finished_reg && !endless_reg))
        else $error("start transfer did not clear the step state");

    a_finished_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_kind_reg == KIND_TICK && finished_reg)
        |=> (finished_reg && $stable(elapsed_reg)))
        else $error("tick changed state after step end");

    a_ramp_start_ramping: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_reg.ramp_start) |-> res_reg.ramping)
        else $error("ramp start without ramping");

    a_stage_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (res_reg.stage <= ST_OVER))
        else $error("result stage code out of range");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with an empty input register");
`endif

endmodule
